// ===== sv/pfo_pkg.sv =====
// Shared widths, register codes and segment codes for the periodic fade opacity block.
// No dependencies; used by pfo_div_pipe and periodic_fade_opacity_core.
package pfo_pkg;

  // Fixed field widths
  localparam int unsigned NOW_W     = 32;
  localparam int unsigned VIS_W     = 17;
  localparam int unsigned RAMP_W    = 14;
  localparam int unsigned CYCLE_W   = 19;  // visible + hidden + 2 * ramp at full width
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 17;

  localparam int unsigned DEF_TIME_BITS     = 32;
  localparam int unsigned DEF_FRACTION_BITS = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE,
    CFG_VISIBLE,
    CFG_HIDDEN,
    CFG_RAMP
  } cfg_idx_e;

  // Part of the cycle that a phase falls in
  typedef enum logic [1:0] {
    SEG_FULL,
    SEG_FADE_OUT,
    SEG_DARK,
    SEG_FADE_IN
  } seg_e;

endpackage

// ===== sv/pfo_mod_pipe.sv =====
// Pipelined restoring modulo: timestamp mod cycle length, one quotient bit per stage.
// Depends on nothing but its parameters; instantiated by periodic_fade_opacity_core.
module pfo_mod_pipe #(
  parameter int unsigned TW = 32,
  parameter int unsigned CW = 19
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [CW-1:0] cycle_i,
  input  logic          valid_i,
  input  logic [TW-1:0] now_i,
  output logic          ready_o,
  output logic          valid_o,
  output logic [CW-1:0] rem_o,
  input  logic          ready_i
);

  logic [TW-1:0] valid_q;
  logic [TW-1:0] take;
  logic [CW-1:0] rem_q [TW];
  logic [TW-1:0] now_q [TW];

  for (genvar k = 0; k < TW; k++) begin : g_stage
    logic          prev_valid;
    logic [CW-1:0] prev_rem;
    logic [TW-1:0] prev_now;
    logic [CW:0]   trial;
    logic [CW-1:0] rem_d;

    if (k == 0) begin : g_first
      assign prev_valid = valid_i;
      assign prev_rem   = '0;
      assign prev_now   = now_i;
    end else begin : g_next
      assign prev_valid = valid_q[k-1];
      assign prev_rem   = rem_q[k-1];
      assign prev_now   = now_q[k-1];
    end

    // A stage loads when it is empty or its content moves on
    if (k == TW - 1) begin : g_last
      assign take[k] = !valid_q[k] || ready_i;
    end else begin : g_mid
      assign take[k] = !valid_q[k] || take[k+1];
    end

    // Shift in the next timestamp bit, then subtract the cycle if it fits
    assign trial = {prev_rem, prev_now[TW-1]};

    always_comb begin
      if (trial >= {1'b0, cycle_i}) begin
        rem_d = CW'(trial - {1'b0, cycle_i});
      end else begin
        rem_d = trial[CW-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (take[k]) begin
        valid_q[k] <= prev_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (take[k]) begin
        rem_q[k] <= rem_d;
        now_q[k] <= {prev_now[TW-2:0], 1'b0};
      end
    end
  end

  assign ready_o = take[0];
  assign valid_o = valid_q[TW-1];
  assign rem_o   = rem_q[TW-1];

endmodule

// ===== sv/pfo_div_pipe.sv =====
// Pipelined restoring divider for the fade ramps: floor(offset * 2^FB / ramp).
// Depends on pfo_pkg for the segment code that rides along with each beat.
module pfo_div_pipe #(
  parameter int unsigned FB = 12,
  parameter int unsigned RW = 14
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [RW-1:0] ramp_i,
  input  logic          valid_i,
  input  logic [RW-1:0] offset_i,
  input  pfo_pkg::seg_e seg_i,
  output logic          ready_o,
  output logic          valid_o,
  output logic [FB-1:0] quo_o,
  output pfo_pkg::seg_e seg_o,
  input  logic          ready_i
);

  logic [FB-1:0] valid_q;
  logic [FB-1:0] take;
  logic [RW-1:0] rem_q [FB];
  logic [FB-1:0] quo_q [FB];
  pfo_pkg::seg_e seg_q [FB];

  for (genvar k = 0; k < FB; k++) begin : g_stage
    logic          prev_valid;
    logic [RW-1:0] prev_rem;
    logic [FB-1:0] prev_quo;
    pfo_pkg::seg_e prev_seg;
    logic [RW:0]   trial;
    logic [RW-1:0] rem_d;
    logic          bit_d;

    if (k == 0) begin : g_first
      assign prev_valid = valid_i;
      assign prev_rem   = offset_i;
      assign prev_quo   = '0;
      assign prev_seg   = seg_i;
    end else begin : g_next
      assign prev_valid = valid_q[k-1];
      assign prev_rem   = rem_q[k-1];
      assign prev_quo   = quo_q[k-1];
      assign prev_seg   = seg_q[k-1];
    end

    if (k == FB - 1) begin : g_last
      assign take[k] = !valid_q[k] || ready_i;
    end else begin : g_mid
      assign take[k] = !valid_q[k] || take[k+1];
    end

    // Offset stays below the ramp, so each step yields one quotient bit
    assign trial = {prev_rem, 1'b0};

    always_comb begin
      if (trial >= {1'b0, ramp_i}) begin
        rem_d = RW'(trial - {1'b0, ramp_i});
        bit_d = 1'b1;
      end else begin
        rem_d = trial[RW-1:0];
        bit_d = 1'b0;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (take[k]) begin
        valid_q[k] <= prev_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (take[k]) begin
        rem_q[k] <= rem_d;
        quo_q[k] <= {prev_quo[FB-2:0], bit_d};
        seg_q[k] <= prev_seg;
      end
    end
  end

  assign ready_o = take[0];
  assign valid_o = valid_q[FB-1];
  assign quo_o   = quo_q[FB-1];
  assign seg_o   = seg_q[FB-1];

endmodule

// ===== sv/periodic_fade_opacity_core.sv =====
// Top level of the periodic fade opacity block: config registers, segment select, output.
// Depends on pfo_pkg, pfo_mod_pipe and pfo_div_pipe.
//
// Takes one timestamp beat per cycle while in_stall_o is low and returns one opacity
// beat for each, in order, with FRACTION_BITS fraction bits (2^FRACTION_BITS is fully
// opaque). The pipeline has one stage per bit of the timestamp modulo, one
// segment-select stage, one stage per quotient bit of the ramp divider and the output
// register. Every stage holds its own beat, so bubbles close up while the output is
// stalled and, while it is not stalled, throughput stays at one beat per cycle. Write the
// configuration only while no beat is in flight; a write is taken every cycle, and the
// timestamp input stalls during a write and for the cycle after it while the cycle
// length settles.
module periodic_fade_opacity_core #(
  parameter int unsigned TIME_BITS     = pfo_pkg::DEF_TIME_BITS,
  parameter int unsigned FRACTION_BITS = pfo_pkg::DEF_FRACTION_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pfo_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pfo_pkg::CFG_DAT_W-1:0]      cfg_data_i,
  // timestamp in
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [pfo_pkg::NOW_W-1:0]          now_ms_i,
  // opacity out
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [FRACTION_BITS:0]             opacity_o
);

  localparam int unsigned TW = (TIME_BITS < pfo_pkg::NOW_W) ? TIME_BITS : pfo_pkg::NOW_W;
  localparam int unsigned CW = pfo_pkg::CYCLE_W;
  localparam int unsigned RW = pfo_pkg::RAMP_W;
  localparam logic [FRACTION_BITS:0] One = {1'b1, {FRACTION_BITS{1'b0}}};

  // ---------------- configuration registers
  logic                         enable_q;
  logic [pfo_pkg::VIS_W-1:0]    visible_q;
  logic [pfo_pkg::VIS_W-1:0]    hidden_q;
  logic [RW-1:0]                ramp_q;
  logic [CW-1:0]                cycle_q;
  logic [CW-1:0]                out_end_q;
  logic [CW-1:0]                dark_end_q;
  logic                         cfg_settle_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b0;
      visible_q <= '0;
      hidden_q  <= '0;
      ramp_q    <= '0;
    end else if (cfg_valid_i) begin
      unique case (pfo_pkg::cfg_idx_e'(cfg_index_i))
        pfo_pkg::CFG_ENABLE:  enable_q  <= cfg_data_i[0];
        pfo_pkg::CFG_VISIBLE: visible_q <= cfg_data_i[pfo_pkg::VIS_W-1:0];
        pfo_pkg::CFG_HIDDEN:  hidden_q  <= cfg_data_i[pfo_pkg::VIS_W-1:0];
        pfo_pkg::CFG_RAMP:    ramp_q    <= cfg_data_i[RW-1:0];
      endcase
    end
  end

  // Segment boundaries, refreshed every cycle from the registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycle_q      <= '0;
      out_end_q    <= '0;
      dark_end_q   <= '0;
      cfg_settle_q <= 1'b0;
    end else begin
      out_end_q    <= CW'(visible_q) + CW'(ramp_q);
      dark_end_q   <= CW'(visible_q) + CW'(ramp_q) + CW'(hidden_q);
      cycle_q      <= CW'(visible_q) + CW'(hidden_q) + CW'({ramp_q, 1'b0});
      cfg_settle_q <= cfg_valid_i;
    end
  end

  // ---------------- phase = now mod cycle
  logic          mod_ready;
  logic          mod_valid;
  logic [CW-1:0] phase;
  logic          seg_take;
  logic          in_hold;

  // Hold timestamps until the cycle length reflects the last write
  assign in_hold = cfg_valid_i || cfg_settle_q;

  pfo_mod_pipe #(
    .TW (TW),
    .CW (CW)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cycle_i (cycle_q),
    .valid_i (in_valid_i && !in_hold),
    .now_i   (now_ms_i[TW-1:0]),
    .ready_o (mod_ready),
    .valid_o (mod_valid),
    .rem_o   (phase),
    .ready_i (seg_take)
  );

  assign in_stall_o = !mod_ready || in_hold;

  // ---------------- segment select
  logic          seg_valid_q;
  pfo_pkg::seg_e seg_q;
  pfo_pkg::seg_e seg_d;
  logic [RW-1:0] offset_q;
  logic [RW-1:0] offset_d;
  logic          div_ready;

  assign seg_take = !seg_valid_q || div_ready;

  always_comb begin
    offset_d = '0;
    priority if (!enable_q || (cycle_q == '0)) begin
      seg_d = pfo_pkg::SEG_FULL;
    end else if (phase < CW'(visible_q)) begin
      seg_d = pfo_pkg::SEG_FULL;
    end else if (phase < out_end_q) begin
      seg_d    = pfo_pkg::SEG_FADE_OUT;
      offset_d = RW'(phase - CW'(visible_q));
    end else if (phase < dark_end_q) begin
      seg_d = pfo_pkg::SEG_DARK;
    end else if (phase < cycle_q) begin
      seg_d    = pfo_pkg::SEG_FADE_IN;
      offset_d = RW'(phase - dark_end_q);
    end else begin
      seg_d = pfo_pkg::SEG_FULL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_valid_q <= 1'b0;
    end else if (seg_take) begin
      seg_valid_q <= mod_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seg_take) begin
      seg_q    <= seg_d;
      offset_q <= offset_d;
    end
  end

  // ---------------- ramp divide
  logic                     div_valid;
  logic [FRACTION_BITS-1:0] quo;
  pfo_pkg::seg_e            div_seg;
  logic                     out_take;

  pfo_div_pipe #(
    .FB (FRACTION_BITS),
    .RW (RW)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ramp_i   (ramp_q),
    .valid_i  (seg_valid_q),
    .offset_i (offset_q),
    .seg_i    (seg_q),
    .ready_o  (div_ready),
    .valid_o  (div_valid),
    .quo_o    (quo),
    .seg_o    (div_seg),
    .ready_i  (out_take)
  );

  // ---------------- output register
  logic                   out_valid_q;
  logic [FRACTION_BITS:0] opacity_q;
  logic [FRACTION_BITS:0] opacity_d;

  assign out_take = !out_valid_q || !out_stall_i;

  always_comb begin
    unique case (div_seg)
      pfo_pkg::SEG_FULL:     opacity_d = One;
      pfo_pkg::SEG_FADE_OUT: opacity_d = One - {1'b0, quo};
      pfo_pkg::SEG_DARK:     opacity_d = '0;
      pfo_pkg::SEG_FADE_IN:  opacity_d = {1'b0, quo};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_take) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take) begin
      opacity_q <= opacity_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign opacity_o   = opacity_q;

endmodule

// ===== dv/tb_periodic_fade_opacity_core.sv =====
`timescale 1ns / 1ps
// Testbench for periodic_fade_opacity_core: directed and random timestamps checked against
// a local opacity predictor. Depends on pfo_pkg and the RTL of the block only.
module tb_periodic_fade_opacity_core;

  localparam int unsigned FRACTION_BITS  = pfo_pkg::DEF_FRACTION_BITS;
  localparam int unsigned LATENCY        = 46;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned PHASES         = 10;
  localparam int unsigned PHASE_ITEMS    = 108;

  typedef logic [FRACTION_BITS:0] opacity_t;
  typedef logic [pfo_pkg::NOW_W-1:0] stamp_t;
  typedef logic [pfo_pkg::CFG_DAT_W-1:0] cfg_data_t;
  typedef struct packed {
    stamp_t   stamp;
    opacity_t opacity;
  } fade_sample_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  pfo_pkg::cfg_idx_e    cfg_index_i = pfo_pkg::CFG_ENABLE;
  cfg_data_t            cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  stamp_t               now_ms_i    = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  opacity_t             opacity_o;

  // Local copy of the block's configuration, at its reset values
  logic                         fade_enable  = 1'b0;
  logic [pfo_pkg::VIS_W-1:0]    fade_visible = '0;
  logic [pfo_pkg::VIS_W-1:0]    fade_hidden  = '0;
  logic [pfo_pkg::RAMP_W-1:0]   fade_ramp    = '0;

  fade_sample_t expected_opacity_q[$];
  int unsigned  mismatch_count;
  int unsigned  quiet_cycles;
  int unsigned  burst_left;
  bit           gaps_on;
  int unsigned  stall_mode;
  int unsigned  stall_span;
  int unsigned  stall_period;
  int unsigned  stall_tick;

  periodic_fade_opacity_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .now_ms_i    (now_ms_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .opacity_o   (opacity_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic opacity_t predict_opacity(input stamp_t stamp);
    logic [63:0] full_scale;
    logic [63:0] cycle;
    logic [63:0] ph;
    full_scale = 64'd1 << FRACTION_BITS;
    if (!fade_enable) return opacity_t'(full_scale);
    cycle = 64'(fade_visible) + 64'(fade_hidden) + 2 * 64'(fade_ramp);
    if (cycle == 0) return opacity_t'(full_scale);
    ph = 64'(stamp) % cycle;
    if (ph < 64'(fade_visible)) return opacity_t'(full_scale);
    ph -= 64'(fade_visible);
    if (ph < 64'(fade_ramp)) return opacity_t'(full_scale - (ph * full_scale) / 64'(fade_ramp));
    ph -= 64'(fade_ramp);
    if (ph < 64'(fade_hidden)) return '0;
    ph -= 64'(fade_hidden);
    if (ph < 64'(fade_ramp)) return opacity_t'((ph * full_scale) / 64'(fade_ramp));
    return opacity_t'(full_scale);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Track config writes, predict each accepted timestamp, check each accepted opacity
  always @(posedge clk_i) begin : monitor
    fade_sample_t head;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        pfo_pkg::CFG_ENABLE:  fade_enable  = cfg_data_i[0];
        pfo_pkg::CFG_VISIBLE: fade_visible = cfg_data_i[pfo_pkg::VIS_W-1:0];
        pfo_pkg::CFG_HIDDEN:  fade_hidden  = cfg_data_i[pfo_pkg::VIS_W-1:0];
        pfo_pkg::CFG_RAMP:    fade_ramp    = cfg_data_i[pfo_pkg::RAMP_W-1:0];
        default: ;
      endcase
    end
    if (in_valid_i && !in_stall_o)
      expected_opacity_q.push_back('{stamp: now_ms_i, opacity: predict_opacity(now_ms_i)});
    if (out_valid_o && !out_stall_i) begin
      if (expected_opacity_q.size() == 0) begin
        report_mismatch($sformatf("opacity %0d with no timestamp pending", opacity_o));
      end else begin
        head = expected_opacity_q.pop_front();
        if (opacity_o !== head.opacity)
          report_mismatch($sformatf("now_ms %0d: opacity %0d, expected %0d",
                                    head.stamp, opacity_o, head.opacity));
      end
    end
    if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && !in_stall_o) ||
        (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("[%0t] watchdog: no beat accepted for %0d cycles", $realtime, WATCHDOG_LIMIT);
    $display("status: fail");
    $finish;
  end

  // Receiver: switch among no stall, light and heavy random stall, and a periodic pattern
  always @(negedge clk_i) begin : receiver
    if (stall_span == 0) begin
      stall_mode   = $urandom_range(0, 3);
      stall_span   = $urandom_range(64, 300);
      stall_period = $urandom_range(2, 9);
    end
    stall_span--;
    stall_tick++;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 99) < 30);
      2: out_stall_i <= ($urandom_range(0, 99) < 70);
      default: out_stall_i <= ((stall_tick % stall_period) < (stall_period / 2));
    endcase
  end

  task automatic write_reg(input pfo_pkg::cfg_idx_e idx, input cfg_data_t data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic configure_fade(input cfg_data_t en, input cfg_data_t vis,
                                input cfg_data_t hid, input cfg_data_t ramp);
    write_reg(pfo_pkg::CFG_ENABLE, en);
    write_reg(pfo_pkg::CFG_VISIBLE, vis);
    write_reg(pfo_pkg::CFG_HIDDEN, hid);
    write_reg(pfo_pkg::CFG_RAMP, ramp);
  endtask

  task automatic send_timestamp(input stamp_t stamp);
    if (gaps_on && burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    if (burst_left != 0) burst_left--;
    in_valid_i <= 1'b1;
    now_ms_i   <= stamp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drop valid and hold until every pending opacity has been returned
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (expected_opacity_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_reset_state();
    send_timestamp('0);
    send_timestamp('1);
  endtask

  task automatic test_disabled();
    drain_pipeline();
    // enable bit low with every upper data bit set
    configure_fade(17'h1FFFE, 17'd5, 17'd5, 17'd5);
    send_timestamp(32'hAAAA_AAAA);
    send_timestamp(32'h5555_5555);
  endtask

  task automatic test_segments();
    drain_pipeline();
    configure_fade(17'd1, 17'd3, 17'd2, 17'd3);
    for (int unsigned ph = 0; ph < 11; ph++) send_timestamp(32'(ph));
    // zero ramp: upper data bits are outside the ramp field and must be dropped
    drain_pipeline();
    configure_fade(17'd1, 17'd2, 17'd3, 17'h1C000);
    send_timestamp(32'd1);
    send_timestamp(32'd2);
    send_timestamp(32'd4);
    // ramps only: zero visible and zero hidden
    drain_pipeline();
    configure_fade(17'd1, 17'd0, 17'd0, 17'd5);
    send_timestamp(32'd0);
    send_timestamp(32'd4);
    send_timestamp(32'd9);
  endtask

  task automatic test_extremes();
    drain_pipeline();
    configure_fade(17'd1, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
    send_timestamp('1);
    send_timestamp(32'd131071);
    send_timestamp(32'd131071 + 32'd16382);
    // enabled with a zero-length cycle
    drain_pipeline();
    configure_fade(17'd1, 17'd0, 17'd0, 17'd0);
    send_timestamp('1);
  endtask

  function automatic cfg_data_t pick_length(input cfg_data_t span_max);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return pfo_pkg::CFG_DAT_W'($urandom_range(1, 12));
      2, 3: return pfo_pkg::CFG_DAT_W'($urandom_range(1, span_max));
      4: return span_max;
      default: return pfo_pkg::CFG_DAT_W'($urandom);
    endcase
  endfunction

  task automatic test_random();
    logic [63:0] cycle;
    logic [63:0] seg_start;
    logic [63:0] k;
    stamp_t      stamp;
    int unsigned hold_at;
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      drain_pipeline();
      gaps_on = ($urandom_range(0, 3) != 0);
      configure_fade(pfo_pkg::CFG_DAT_W'({$urandom_range(0, 65535), 1'b0}) |
                         pfo_pkg::CFG_DAT_W'($urandom_range(0, 99) < 85),
                     pick_length(17'd120000), pick_length(17'd120000),
                     pick_length(17'd10000));
      hold_at = $urandom_range(10, PHASE_ITEMS - 10);
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        if (n == hold_at) drain_pipeline();
        cycle = 64'(fade_visible) + 64'(fade_hidden) + 2 * 64'(fade_ramp);
        case ($urandom_range(0, 3))
          0, 1: stamp = $urandom;
          2: begin
            if (cycle == 0) begin
              stamp = $urandom;
            end else begin
              // land within two ms of a segment edge
              case ($urandom_range(0, 3))
                0: seg_start = 0;
                1: seg_start = 64'(fade_visible);
                2: seg_start = 64'(fade_visible) + 64'(fade_ramp);
                default: seg_start = cycle - 64'(fade_ramp);
              endcase
              k = 64'($urandom) % ((64'h1_0000_0000 / cycle) + 1);
              stamp = pfo_pkg::NOW_W'(k * cycle + seg_start + 64'($urandom_range(0, 4))
                                      - 64'd2);
            end
          end
          default: stamp = $urandom_range(0, 1000);
        endcase
        send_timestamp(stamp);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_state();
    test_disabled();
    test_segments();
    test_extremes();
    test_random();
    drain_pipeline();
    repeat (2 * LATENCY) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/pfo_pkg.sv
sv/pfo_mod_pipe.sv
sv/pfo_div_pipe.sv
sv/periodic_fade_opacity_core.sv
dv/tb_periodic_fade_opacity_core.sv
